FILE: src/tetrahedron_dos_contribution_unit_macros.svh
// Assertion macros for the tetrahedron DOS contribution unit.
`ifndef TETRAHEDRON_DOS_CONTRIBUTION_UNIT_MACROS_SVH
`define TETRAHEDRON_DOS_CONTRIBUTION_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TDOS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication across a fixed number of cycles.
`define TDOS_ASSERT_DLY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##(n) (cons)) \
		else $error(msg);

`endif

FILE: src/tdos_pkg.sv
// Shared types and constants for the tetrahedron DOS contribution unit.
package tdos_pkg;

	localparam int ENERGY_FRAC_BITS = 20;

	localparam int E_W     = 32;
	localparam int W_W     = 33;
	localparam int QB      = 48;
	localparam int VAL_W   = 47;
	localparam int DEN_W   = 128;
	localparam int VMAG_W  = 99;
	localparam int SMAG_W  = 69;
	localparam int NV_W    = VMAG_W + W_W;
	localparam int NS_W    = SMAG_W + W_W;
	localparam int NUM_W   = (NV_W + ENERGY_FRAC_BITS > NS_W + 2 * ENERGY_FRAC_BITS) ?
		NV_W + ENERGY_FRAC_BITS : NS_W + 2 * ENERGY_FRAC_BITS;
	localparam int REM_W   = (DEN_W + 1 + QB > NUM_W + 2) ? DEN_W + 1 + QB : NUM_W + 2;

	localparam int DIV_STAGES   = QB + 2;
	localparam int FRONT_STAGES = 7;
	localparam int LAT          = FRONT_STAGES + DIV_STAGES + 1;

	localparam int K_VAL   = 3;
	localparam int K_SLOPE = 6;

	typedef logic [QB-1:0]     quo_t;
	typedef logic [DEN_W-1:0]  den_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [NV_W-1:0]   nv_t;
	typedef logic [NS_W-1:0]   ns_t;
	typedef logic [VMAG_W-1:0] vmag_t;
	typedef logic [SMAG_W-1:0] smag_t;
	typedef logic [W_W-1:0]    weight_t;

	localparam quo_t    VAL_MAX      = {1'b0, {(QB-1){1'b1}}};
	localparam quo_t    NEG_MAG      = {1'b1, {(QB-1){1'b0}}};
	localparam weight_t WEIGHT_RESET = {1'b1, {(W_W-1){1'b0}}};

	typedef enum logic [1:0] {
		REG_LOW,
		REG_MID,
		REG_HIGH
	} region_t;

	typedef struct packed {
		logic signed [E_W-1:0] energy;
		logic signed [E_W-1:0] vertex_e1;
		logic signed [E_W-1:0] vertex_e2;
		logic signed [E_W-1:0] vertex_e3;
		logic signed [E_W-1:0] vertex_e4;
	} in_item_t;

	typedef struct packed {
		logic [VAL_W-1:0]     dos_value;
		logic signed [QB-1:0] dos_slope;
		logic                 saturated;
		logic                 order_error;
	} out_item_t;

	typedef struct packed {
		logic ok;
		logic order_error;
		logic vneg;
		logic sneg;
	} div_ctl_t;

endpackage

FILE: src/tetrahedron_dos_contribution_unit.sv
// Top level of the tetrahedron-method DOS contribution unit.
// One tetrahedron item (energy plus four ascending vertex energies, Q12.20) enters on any
// cycle with start high; busy never rises, so a new item can be given every cycle. Each
// item's result is on result for exactly one cycle with done high. The item passes through
// the front stages of span products, weight multiply and sums, one divider stage that adds
// the rounding offset and one that checks for quotient overflow, then a restoring divider
// that settles one quotient bit per stage for 48 bits, and the output register; the
// receiver cannot hold results off. The weight register weight_q is written through the
// cfg channel (always ready); the user must write it only while no item is in flight, as
// the block itself does not enforce this.
`include "tetrahedron_dos_contribution_unit_macros.svh"

module tetrahedron_dos_contribution_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tdos_pkg::in_item_t   request,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  tdos_pkg::weight_t    cfg_data,
	output logic                 done,
	output tdos_pkg::out_item_t  result
);

	tdos_pkg::weight_t weight_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= tdos_pkg::WEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			weight_q <= cfg_data;
		end
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// ---- stage 1: spans, order check, region
	logic              ordered_c;
	logic              inside_c;
	tdos_pkg::region_t region_c;

	always_comb begin
		ordered_c = (request.vertex_e1 <= request.vertex_e2) &&
			(request.vertex_e2 <= request.vertex_e3) &&
			(request.vertex_e3 <= request.vertex_e4);
		inside_c  = (request.energy > request.vertex_e1) &&
			(request.energy <= request.vertex_e4);
		if (request.energy <= request.vertex_e2) begin
			region_c = tdos_pkg::REG_LOW;
		end else if (request.energy <= request.vertex_e3) begin
			region_c = tdos_pkg::REG_MID;
		end else begin
			region_c = tdos_pkg::REG_HIGH;
		end
	end

	logic [31:0]       d21_s1, d31_s1, d41_s1, d32_s1, d42_s1, d43_s1;
	logic [31:0]       ex_s1, ey_s1, ez_s1;
	logic              ok_s1, oerr_s1;
	tdos_pkg::region_t rgn_s1;

	always_ff @(posedge clk) begin
		d21_s1  <= request.vertex_e2 - request.vertex_e1;
		d31_s1  <= request.vertex_e3 - request.vertex_e1;
		d41_s1  <= request.vertex_e4 - request.vertex_e1;
		d32_s1  <= request.vertex_e3 - request.vertex_e2;
		d42_s1  <= request.vertex_e4 - request.vertex_e2;
		d43_s1  <= request.vertex_e4 - request.vertex_e3;
		ex_s1   <= request.energy - request.vertex_e1;
		ey_s1   <= request.energy - request.vertex_e2;
		ez_s1   <= request.vertex_e4 - request.energy;
		ok_s1   <= ordered_c && inside_c;
		oerr_s1 <= !ordered_c;
		rgn_s1  <= region_c;
	end

	// ---- stage 2: first 32x32 products
	logic [31:0] f1_c, f2_c, f3_c, t_c;
	logic [32:0] s_c;

	always_comb begin
		s_c = 33'(d31_s1) + 33'(d42_s1);
		unique case (rgn_s1)
			tdos_pkg::REG_LOW: begin
				f1_c = d21_s1;
				f2_c = d31_s1;
				f3_c = d41_s1;
				t_c  = ex_s1;
			end
			tdos_pkg::REG_MID: begin
				f1_c = d31_s1;
				f2_c = d41_s1;
				f3_c = '0;
				t_c  = '0;
			end
			tdos_pkg::REG_HIGH: begin
				f1_c = d41_s1;
				f2_c = d42_s1;
				f3_c = d43_s1;
				t_c  = ez_s1;
			end
			default: begin
				f1_c = '0;
				f2_c = '0;
				f3_c = '0;
				t_c  = '0;
			end
		endcase
	end

	logic [63:0]       p12_s2, m_s2, tt_s2;
	logic [64:0]       sy_s2;
	logic [32:0]       u_s2;
	logic [31:0]       f3_s2, ey_s2, t_s2;
	logic              ok_s2, oerr_s2;
	tdos_pkg::region_t rgn_s2;

	always_ff @(posedge clk) begin
		p12_s2  <= 64'(f1_c) * 64'(f2_c);
		m_s2    <= 64'(d32_s1) * 64'(d42_s1);
		tt_s2   <= 64'(t_c) * 64'(t_c);
		sy_s2   <= 65'(s_c) * 65'(ey_s1);
		u_s2    <= 33'(d21_s1) + {ey_s1, 1'b0};
		f3_s2   <= f3_c;
		ey_s2   <= ey_s1;
		t_s2    <= t_c;
		ok_s2   <= ok_s1;
		oerr_s2 <= oerr_s1;
		rgn_s2  <= rgn_s1;
	end

	// ---- stage 3: partial products of the wide terms
	logic [63:0] g_c;

	assign g_c = (rgn_s2 == tdos_pkg::REG_MID) ? m_s2 : 64'(f3_s2);

	logic [63:0]       pp00_s3, pp01_s3, pp10_s3, pp11_s3;
	logic [64:0]       mu0_s3, mu1_s3;
	logic [63:0]       sy0_s3;
	logic [64:0]       sy1_s3;
	logic [65:0]       sd_s3;
	logic [63:0]       tt_s3;
	logic [31:0]       t_s3;
	logic              ok_s3, oerr_s3;
	tdos_pkg::region_t rgn_s3;

	always_ff @(posedge clk) begin
		pp00_s3 <= 64'(p12_s2[31:0]) * 64'(g_c[31:0]);
		pp01_s3 <= 64'(p12_s2[31:0]) * 64'(g_c[63:32]);
		pp10_s3 <= 64'(p12_s2[63:32]) * 64'(g_c[31:0]);
		pp11_s3 <= 64'(p12_s2[63:32]) * 64'(g_c[63:32]);
		mu0_s3  <= 65'(m_s2[31:0]) * 65'(u_s2);
		mu1_s3  <= 65'(m_s2[63:32]) * 65'(u_s2);
		sy0_s3  <= 64'(sy_s2[31:0]) * 64'(ey_s2);
		sy1_s3  <= 65'(sy_s2[64:32]) * 65'(ey_s2);
		sd_s3   <= 66'(m_s2) - 66'(sy_s2);
		tt_s3   <= tt_s2;
		t_s3    <= t_s2;
		ok_s3   <= ok_s2;
		oerr_s3 <= oerr_s2;
		rgn_s3  <= rgn_s2;
	end

	// ---- stage 4: sum partials, slope numerator
	logic [65:0]     sabs_c;
	tdos_pkg::smag_t smag_c;
	logic            sneg_c;

	always_comb begin
		sabs_c = sd_s3[65] ? (66'd0 - sd_s3) : sd_s3;
		unique case (rgn_s3)
			tdos_pkg::REG_LOW: begin
				smag_c = tdos_pkg::smag_t'(t_s3) * tdos_pkg::smag_t'(tdos_pkg::K_SLOPE);
				sneg_c = 1'b0;
			end
			tdos_pkg::REG_MID: begin
				smag_c = tdos_pkg::smag_t'(sabs_c) * tdos_pkg::smag_t'(tdos_pkg::K_SLOPE);
				sneg_c = sd_s3[65];
			end
			tdos_pkg::REG_HIGH: begin
				smag_c = tdos_pkg::smag_t'(t_s3) * tdos_pkg::smag_t'(tdos_pkg::K_SLOPE);
				sneg_c = 1'b1;
			end
			default: begin
				smag_c = '0;
				sneg_c = 1'b0;
			end
		endcase
	end

	tdos_pkg::den_t    den_s4;
	logic [96:0]       mu_s4, syy_s4;
	logic [63:0]       tt_s4;
	tdos_pkg::smag_t   smag_s4;
	logic              sneg_s4, ok_s4, oerr_s4;
	tdos_pkg::region_t rgn_s4;

	always_ff @(posedge clk) begin
		den_s4  <= tdos_pkg::den_t'(pp00_s3) + (tdos_pkg::den_t'(pp01_s3) << 32) +
			(tdos_pkg::den_t'(pp10_s3) << 32) + (tdos_pkg::den_t'(pp11_s3) << 64);
		mu_s4   <= 97'(mu0_s3) + (97'(mu1_s3) << 32);
		syy_s4  <= 97'(sy0_s3) + (97'(sy1_s3) << 32);
		tt_s4   <= tt_s3;
		smag_s4 <= smag_c;
		sneg_s4 <= sneg_c;
		ok_s4   <= ok_s3;
		oerr_s4 <= oerr_s3;
		rgn_s4  <= rgn_s3;
	end

	// ---- stage 5: value numerator; negative means the value clips at zero
	logic [97:0]     vd_c;
	tdos_pkg::vmag_t vmag_c;
	logic            vneg_c;

	always_comb begin
		vd_c = 98'(mu_s4) - 98'(syy_s4);
		unique case (rgn_s4) inside
			tdos_pkg::REG_LOW, tdos_pkg::REG_HIGH: begin
				vmag_c = tdos_pkg::vmag_t'(tt_s4) * tdos_pkg::vmag_t'(tdos_pkg::K_VAL);
				vneg_c = 1'b0;
			end
			tdos_pkg::REG_MID: begin
				vmag_c = tdos_pkg::vmag_t'(vd_c[96:0]) * tdos_pkg::vmag_t'(tdos_pkg::K_VAL);
				vneg_c = vd_c[97];
			end
			default: begin
				vmag_c = '0;
				vneg_c = 1'b0;
			end
		endcase
	end

	tdos_pkg::den_t  den_s5;
	tdos_pkg::vmag_t vmag_s5;
	tdos_pkg::smag_t smag_s5;
	logic            vneg_s5, sneg_s5, ok_s5, oerr_s5;

	always_ff @(posedge clk) begin
		den_s5  <= den_s4;
		vmag_s5 <= vmag_c;
		vneg_s5 <= vneg_c;
		smag_s5 <= smag_s4;
		sneg_s5 <= sneg_s4;
		ok_s5   <= ok_s4;
		oerr_s5 <= oerr_s4;
	end

	// ---- stage 6: weight partial products
	logic [64:0]    pv0_s6, pv1_s6, pv2_s6;
	logic [35:0]    pv3_s6;
	logic [64:0]    ps0_s6, ps1_s6;
	logic [37:0]    ps2_s6;
	tdos_pkg::den_t den_s6;
	logic           vneg_s6, sneg_s6, ok_s6, oerr_s6;

	always_ff @(posedge clk) begin
		pv0_s6  <= 65'(vmag_s5[31:0]) * 65'(weight_q);
		pv1_s6  <= 65'(vmag_s5[63:32]) * 65'(weight_q);
		pv2_s6  <= 65'(vmag_s5[95:64]) * 65'(weight_q);
		pv3_s6  <= 36'(vmag_s5[tdos_pkg::VMAG_W-1:96]) * 36'(weight_q);
		ps0_s6  <= 65'(smag_s5[31:0]) * 65'(weight_q);
		ps1_s6  <= 65'(smag_s5[63:32]) * 65'(weight_q);
		ps2_s6  <= 38'(smag_s5[tdos_pkg::SMAG_W-1:64]) * 38'(weight_q);
		den_s6  <= den_s5;
		vneg_s6 <= vneg_s5;
		sneg_s6 <= sneg_s5;
		ok_s6   <= ok_s5;
		oerr_s6 <= oerr_s5;
	end

	// ---- stage 7: weighted numerators
	tdos_pkg::nv_t  nv_s7;
	tdos_pkg::ns_t  ns_s7;
	tdos_pkg::den_t den_s7;
	logic           vneg_s7, sneg_s7, ok_s7, oerr_s7;

	always_ff @(posedge clk) begin
		nv_s7   <= tdos_pkg::nv_t'(pv0_s6) + (tdos_pkg::nv_t'(pv1_s6) << 32) +
			(tdos_pkg::nv_t'(pv2_s6) << 64) + (tdos_pkg::nv_t'(pv3_s6) << 96);
		ns_s7   <= tdos_pkg::ns_t'(ps0_s6) + (tdos_pkg::ns_t'(ps1_s6) << 32) +
			(tdos_pkg::ns_t'(ps2_s6) << 64);
		den_s7  <= den_s6;
		vneg_s7 <= vneg_s6;
		sneg_s7 <= sneg_s6;
		ok_s7   <= ok_s6;
		oerr_s7 <= oerr_s6;
	end

	// ---- divider
	tdos_pkg::div_ctl_t div_in_ctl;
	tdos_pkg::num_t     div_num_v, div_num_s;
	logic               div_vld, div_ovf_v, div_ovf_s;
	tdos_pkg::div_ctl_t div_ctl;
	tdos_pkg::quo_t     div_quo_v, div_quo_s;

	assign div_in_ctl = '{ok: ok_s7, order_error: oerr_s7, vneg: vneg_s7, sneg: sneg_s7};
	assign div_num_v  = tdos_pkg::num_t'(nv_s7) << tdos_pkg::ENERGY_FRAC_BITS;
	assign div_num_s  = tdos_pkg::num_t'(ns_s7) << (2 * tdos_pkg::ENERGY_FRAC_BITS);

	tdos_div_pipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s7),
		.in_ctl    (div_in_ctl),
		.num_v     (div_num_v),
		.num_s     (div_num_s),
		.den       (den_s7),
		.out_valid (div_vld),
		.out_ctl   (div_ctl),
		.quo_v     (div_quo_v),
		.quo_s     (div_quo_s),
		.ovf_v     (div_ovf_v),
		.ovf_s     (div_ovf_s)
	);

	// ---- clip, sign and register the result
	tdos_pkg::out_item_t res_c;
	tdos_pkg::quo_t      val_c, slope_c;
	logic                sat_c;

	always_comb begin
		val_c   = '0;
		slope_c = '0;
		sat_c   = 1'b0;
		if (div_ctl.ok && !div_ctl.order_error) begin
			if (div_ctl.vneg) begin
				sat_c = 1'b1;
			end else if (div_ovf_v || div_quo_v > tdos_pkg::VAL_MAX) begin
				val_c = tdos_pkg::VAL_MAX;
				sat_c = 1'b1;
			end else begin
				val_c = div_quo_v;
			end
			if (!div_ctl.sneg) begin
				if (div_ovf_s || div_quo_s > tdos_pkg::VAL_MAX) begin
					slope_c = tdos_pkg::VAL_MAX;
					sat_c   = 1'b1;
				end else begin
					slope_c = div_quo_s;
				end
			end else if (div_ovf_s || div_quo_s > tdos_pkg::NEG_MAG) begin
				slope_c = tdos_pkg::NEG_MAG;
				sat_c   = 1'b1;
			end else begin
				slope_c = tdos_pkg::quo_t'(0) - div_quo_s;
			end
		end
		res_c.dos_value   = val_c[tdos_pkg::VAL_W-1:0];
		res_c.dos_slope   = slope_c;
		res_c.saturated   = sat_c;
		res_c.order_error = div_ctl.order_error;
	end

	logic                done_q;
	tdos_pkg::out_item_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_c;
	end

	assign done   = done_q;
	assign result = result_q;

	`TDOS_ASSERT_DLY(a_fixed_latency, start && !busy, tdos_pkg::LAT, done, "item lost in pipeline")
	`TDOS_ASSERT_IMP(a_no_spurious, done, $past(start && !busy, tdos_pkg::LAT), "result without item")
	`TDOS_ASSERT_IMP(a_order_zero, done && result.order_error, result.dos_value == '0 && result.dos_slope == '0 && !result.saturated, "order error with nonzero result")

endmodule

FILE: src/tdos_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, value and slope side by side.
module tdos_div_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  tdos_pkg::div_ctl_t   in_ctl,
	input  tdos_pkg::num_t       num_v,
	input  tdos_pkg::num_t       num_s,
	input  tdos_pkg::den_t       den,
	output logic                 out_valid,
	output tdos_pkg::div_ctl_t   out_ctl,
	output tdos_pkg::quo_t       quo_v,
	output tdos_pkg::quo_t       quo_s,
	output logic                 ovf_v,
	output logic                 ovf_s
);

	logic                       vld_s   [tdos_pkg::DIV_STAGES];
	tdos_pkg::div_ctl_t         ctl_s   [tdos_pkg::DIV_STAGES];
	tdos_pkg::rem_t             rem_v_s [tdos_pkg::DIV_STAGES];
	tdos_pkg::rem_t             rem_s_s [tdos_pkg::DIV_STAGES];
	logic [tdos_pkg::DEN_W:0]   dvs_s   [tdos_pkg::DIV_STAGES];
	tdos_pkg::quo_t             quo_v_s [tdos_pkg::DIV_STAGES];
	tdos_pkg::quo_t             quo_s_s [tdos_pkg::DIV_STAGES];
	logic                       ovf_v_s [tdos_pkg::DIV_STAGES];
	logic                       ovf_s_s [tdos_pkg::DIV_STAGES];

	// stage 0: round to nearest by dividing (2N + D) by 2D
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s[0]   <= in_ctl;
		rem_v_s[0] <= (tdos_pkg::rem_t'(num_v) << 1) + tdos_pkg::rem_t'(den);
		rem_s_s[0] <= (tdos_pkg::rem_t'(num_s) << 1) + tdos_pkg::rem_t'(den);
		dvs_s[0]   <= {den, 1'b0};
		quo_v_s[0] <= '0;
		quo_s_s[0] <= '0;
		ovf_v_s[0] <= 1'b0;
		ovf_s_s[0] <= 1'b0;
	end

	// stage 1: quotient too large for QB bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else begin
			vld_s[1] <= vld_s[0];
		end
	end

	always_ff @(posedge clk) begin
		ctl_s[1]   <= ctl_s[0];
		rem_v_s[1] <= rem_v_s[0];
		rem_s_s[1] <= rem_s_s[0];
		dvs_s[1]   <= dvs_s[0];
		quo_v_s[1] <= '0;
		quo_s_s[1] <= '0;
		ovf_v_s[1] <= rem_v_s[0] >= (tdos_pkg::rem_t'(dvs_s[0]) << tdos_pkg::QB);
		ovf_s_s[1] <= rem_s_s[0] >= (tdos_pkg::rem_t'(dvs_s[0]) << tdos_pkg::QB);
	end

	for (genvar k = 0; k < tdos_pkg::QB; k++) begin : g_step
		tdos_pkg::rem_t shd;
		tdos_pkg::rem_t dif_v;
		tdos_pkg::rem_t dif_s;
		logic           ge_v;
		logic           ge_s;

		assign shd   = tdos_pkg::rem_t'(dvs_s[k+1]) << (tdos_pkg::QB - 1 - k);
		assign ge_v  = rem_v_s[k+1] >= shd;
		assign ge_s  = rem_s_s[k+1] >= shd;
		assign dif_v = rem_v_s[k+1] - shd;
		assign dif_s = rem_s_s[k+1] - shd;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+2] <= 1'b0;
			end else begin
				vld_s[k+2] <= vld_s[k+1];
			end
		end

		always_ff @(posedge clk) begin
			ctl_s[k+2]   <= ctl_s[k+1];
			dvs_s[k+2]   <= dvs_s[k+1];
			ovf_v_s[k+2] <= ovf_v_s[k+1];
			ovf_s_s[k+2] <= ovf_s_s[k+1];
			rem_v_s[k+2] <= ge_v ? dif_v : rem_v_s[k+1];
			rem_s_s[k+2] <= ge_s ? dif_s : rem_s_s[k+1];
			quo_v_s[k+2] <= quo_v_s[k+1] |
				(tdos_pkg::quo_t'(ge_v) << (tdos_pkg::QB - 1 - k));
			quo_s_s[k+2] <= quo_s_s[k+1] |
				(tdos_pkg::quo_t'(ge_s) << (tdos_pkg::QB - 1 - k));
		end
	end

	assign out_valid = vld_s[tdos_pkg::DIV_STAGES-1];
	assign out_ctl   = ctl_s[tdos_pkg::DIV_STAGES-1];
	assign quo_v     = quo_v_s[tdos_pkg::DIV_STAGES-1];
	assign quo_s     = quo_s_s[tdos_pkg::DIV_STAGES-1];
	assign ovf_v     = ovf_v_s[tdos_pkg::DIV_STAGES-1];
	assign ovf_s     = ovf_s_s[tdos_pkg::DIV_STAGES-1];

endmodule
